[src/sm4_block_cipher_cbc_assert.svh]
// Assertion macros for the SM4 cipher block.
// Used by the top level; no other dependencies.
`ifndef SM4_BLOCK_CIPHER_CBC_ASSERT_SVH
`define SM4_BLOCK_CIPHER_CBC_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SM4_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sm4 check failed");

// Next-cycle implication, checked out of reset
`define SM4_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sm4 check failed");

`endif

[src/sm4_pkg.sv]
// Shared types, constants and functions of the SM4 cipher block.
// No dependencies.
package sm4_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAINING = 3'd4;

    localparam int NUM_ROUNDS = 32;
    localparam int ROUND_W    = $clog2(NUM_ROUNDS);

    // Request payloads
    typedef struct packed {
        logic        mode;
        logic        first;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } sm4_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } sm4_out_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_RUN,
        ST_TEXT_LOAD,
        ST_TEXT_RUN,
        ST_FINISH
    } sm4_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic               load_in;
        logic               key_init;
        logic               key_step;
        logic               text_init;
        logic               text_step;
        logic               out_load;
        logic [ROUND_W-1:0] round;
    } sm4_cmd_t;

    // Controller status
    typedef struct packed {
        logic keys_ready;
        logic busy;
    } sm4_status_t;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;
    localparam logic [127:0] FK = {FK0, FK1, FK2, FK3};

    localparam logic [7:0] SBOX [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Byte-wise S-box substitution
    function automatic logic [31:0] tau(input logic [31:0] x);
        logic [31:0] y;
        for (int b = 0; b < 4; b++) begin
            y[8*b +: 8] = SBOX[x[8*b +: 8]];
        end
        return y;
    endfunction

    // CK word i: byte j is (4*i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] i);
        logic [31:0] w;
        logic [7:0]  n;
        for (int j = 0; j < 4; j++) begin
            n = {1'b0, i, 2'(j)};
            w[8*(3-j) +: 8] = 8'(n * 8'd7);
        end
        return w;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

[src/sm4_block_cipher_cbc.sv]
// SM4 block cipher, ECB or CBC. Each request carries one 128-bit block and
// yields one 128-bit result. A block is accepted, then loaded, then runs
// 32 rounds on the single shared round unit, and then writes the result
// register before the next request can be taken. After a key write the next
// block first runs the 32-step key expansion on that same unit. A finished
// result waits in the output register; the next block is accepted meanwhile.
// If that earlier result is still waiting when the next block finishes, the
// block holds in its last cycle until the result is taken.
`include "sm4_block_cipher_cbc_assert.svh"

module sm4_block_cipher_cbc (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sm4_pkg::sm4_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sm4_pkg::sm4_out_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [sm4_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                        cfg_wdata
);

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        chaining_reg;
    logic        key_write;
    sm4_pkg::sm4_cmd_t    cmd;
    sm4_pkg::sm4_status_t status;

    assign key_write = cfg_wr_en
        && ((cfg_index == sm4_pkg::CFG_KEY_HIGH) || (cfg_index == sm4_pkg::CFG_KEY_LOW));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            chaining_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sm4_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_wdata;
                sm4_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                sm4_pkg::CFG_IV_HIGH:  iv_high_reg  <= cfg_wdata;
                sm4_pkg::CFG_IV_LOW:   iv_low_reg   <= cfg_wdata;
                sm4_pkg::CFG_CHAINING: chaining_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    sm4_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .key_write (key_write),
        .cmd       (cmd),
        .status    (status)
    );

    sm4_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_data       (s_data),
        .cfg_key      ({key_high_reg, key_low_reg}),
        .cfg_iv       ({iv_high_reg, iv_low_reg}),
        .cfg_chaining (chaining_reg),
        .m_data       (m_data)
    );

    // Checks
    `SM4_ASSERT_NEXT(a_key_write_clears, aclk, aresetn, key_write, !status.keys_ready)
    `SM4_ASSERT_SAME(a_text_needs_keys, aclk, aresetn, cmd.text_init, status.keys_ready)
    `SM4_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SM4_ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.out_load, m_valid)
    `SM4_ASSERT_SAME(a_busy_blocks_input, aclk, aresetn, status.busy, !s_ready)

endmodule

[src/sm4_ctrl.sv]
// SM4 controller: sequences key expansion, the 32 cipher rounds and
// result hand-off. Depends on sm4_pkg.
module sm4_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  key_write,
    output sm4_pkg::sm4_cmd_t     cmd,
    output sm4_pkg::sm4_status_t  status
);

    sm4_pkg::sm4_state_t state_reg, state_next;
    logic [sm4_pkg::ROUND_W-1:0] cnt_reg, cnt_next;
    logic keys_ready_reg, keys_ready_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic last_round;
    logic out_free;

    assign accept     = s_valid && s_ready;
    assign last_round = (cnt_reg == sm4_pkg::ROUND_W'(sm4_pkg::NUM_ROUNDS - 1));
    assign out_free   = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sm4_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = keys_ready_reg ? sm4_pkg::ST_TEXT_LOAD : sm4_pkg::ST_KEY_RUN;
                end
            end
            sm4_pkg::ST_KEY_RUN: begin
                if (last_round) state_next = sm4_pkg::ST_TEXT_LOAD;
            end
            sm4_pkg::ST_TEXT_LOAD: state_next = sm4_pkg::ST_TEXT_RUN;
            sm4_pkg::ST_TEXT_RUN: begin
                if (last_round) state_next = sm4_pkg::ST_FINISH;
            end
            sm4_pkg::ST_FINISH: begin
                if (out_free) state_next = sm4_pkg::ST_IDLE;
            end
            default: state_next = sm4_pkg::ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cmd.round = cnt_reg;
        unique case (state_reg)
            sm4_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_in  = accept;
                cmd.key_init = accept && !keys_ready_reg;
            end
            sm4_pkg::ST_KEY_RUN:   cmd.key_step  = 1'b1;
            sm4_pkg::ST_TEXT_LOAD: cmd.text_init = 1'b1;
            sm4_pkg::ST_TEXT_RUN:  cmd.text_step = 1'b1;
            sm4_pkg::ST_FINISH:    cmd.out_load  = out_free;
            default: ;
        endcase
    end

    // Round counter, key flag and output flag
    always_comb begin
        cnt_next = '0;
        if (cmd.key_step || cmd.text_step) begin
            cnt_next = cnt_reg + 1'b1;
        end

        keys_ready_next = keys_ready_reg;
        if (key_write) begin
            keys_ready_next = 1'b0;
        end else if (cmd.key_step && last_round) begin
            keys_ready_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sm4_pkg::ST_IDLE;
            cnt_reg        <= '0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign status.keys_ready = keys_ready_reg;
    assign status.busy       = (state_reg != sm4_pkg::ST_IDLE);

endmodule

[src/sm4_dp.sv]
// SM4 datapath: request latch, shared round unit, round key memory,
// CBC chain register and result register. Depends on sm4_pkg.
module sm4_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  sm4_pkg::sm4_cmd_t  cmd,
    input  sm4_pkg::sm4_in_t   s_data,
    input  logic [127:0]       cfg_key,
    input  logic [127:0]       cfg_iv,
    input  logic               cfg_chaining,
    output sm4_pkg::sm4_out_t  m_data
);

    sm4_pkg::sm4_in_t in_reg;
    logic [127:0] x_reg;
    logic [127:0] chain_reg;
    logic [31:0]  rk_reg;
    logic [31:0]  key_mem [sm4_pkg::NUM_ROUNDS];
    sm4_pkg::sm4_out_t out_reg;

    logic [31:0]  opnd, t_in, sub, lin, nx;
    logic [127:0] blk, cv, res, res_out;
    logic [sm4_pkg::ROUND_W-1:0] rd_idx, rd_addr;

    assign blk = {in_reg.block_high, in_reg.block_low};

    // Round function shared by key expansion and the cipher rounds
    always_comb begin
        opnd = cmd.key_step ? sm4_pkg::ck_word(cmd.round) : rk_reg;
        t_in = x_reg[95:64] ^ x_reg[63:32] ^ x_reg[31:0] ^ opnd;
        sub  = sm4_pkg::tau(t_in);
        if (cmd.key_step) begin
            lin = sub ^ sm4_pkg::rotl(sub, 13) ^ sm4_pkg::rotl(sub, 23);
        end else begin
            lin = sub ^ sm4_pkg::rotl(sub, 2) ^ sm4_pkg::rotl(sub, 10)
                ^ sm4_pkg::rotl(sub, 18) ^ sm4_pkg::rotl(sub, 24);
        end
        nx = x_reg[127:96] ^ lin;
    end

    // Chain value in effect for this block, and the final word swap
    always_comb begin
        cv      = (cfg_chaining && in_reg.first) ? cfg_iv : chain_reg;
        res     = {x_reg[31:0], x_reg[63:32], x_reg[95:64], x_reg[127:96]};
        res_out = (cfg_chaining && in_reg.mode) ? (res ^ chain_reg) : res;
    end

    // Key read address: one round ahead, reversed for decryption
    always_comb begin
        rd_idx  = cmd.text_init ? '0 : cmd.round + 1'b1;
        rd_addr = in_reg.mode ? ~rd_idx : rd_idx;
    end

    // Round key memory
    always_ff @(posedge aclk) begin
        if (cmd.key_step) begin
            key_mem[cmd.round] <= nx;
        end
        rk_reg <= key_mem[rd_addr];
    end

    // Working state and request latch
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.key_init) begin
            x_reg <= cfg_key ^ sm4_pkg::FK;
        end else if (cmd.text_init) begin
            x_reg <= (cfg_chaining && !in_reg.mode) ? (blk ^ cv) : blk;
        end else if (cmd.key_step || cmd.text_step) begin
            x_reg <= {x_reg[95:0], nx};
        end
    end

    // Chain register, zero out of reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= '0;
        end else if (cmd.text_init && cfg_chaining && in_reg.first) begin
            chain_reg <= cfg_iv;
        end else if (cmd.out_load && cfg_chaining) begin
            chain_reg <= in_reg.mode ? blk : res;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= res_out;
        end
    end

    assign m_data = out_reg;

endmodule

[tb/sm4_cbc_checker.sv]
// Checker for the SM4 ECB/CBC cipher: tracks register writes, predicts each block.
// Compares results in order. Depends on sm4_pkg for the port types.
`timescale 1ns / 100ps

module sm4_cbc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  sm4_pkg::sm4_in_t              s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  sm4_pkg::sm4_out_t             m_data,
    input  logic                          cfg_wr_en,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_wdata,
    output int                            blocks_in_flight,
    output int                            mismatches
);
    import sm4_pkg::*;

    localparam int MAX_REPORTS = 200;

    // System parameter words of the key schedule
    localparam logic [31:0] SYS_PARAM_0 = 32'hA3B1BAC6;
    localparam logic [31:0] SYS_PARAM_1 = 32'h56AA3350;
    localparam logic [31:0] SYS_PARAM_2 = 32'h677D9197;
    localparam logic [31:0] SYS_PARAM_3 = 32'hB27022DC;

    localparam logic [7:0] SUB_TABLE [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Shadow of the register file and of the cipher state
    logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
    logic        cbc_on_q;
    logic [31:0] round_key [32];
    logic        keys_valid;
    logic [63:0] chain_hi, chain_lo;

    sm4_out_t predicted_blocks [$];

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} << n;
        return twice[63:32];
    endfunction

    function automatic logic [31:0] substitute(input logic [31:0] x);
        logic [31:0] y;
        for (int b = 0; b < 4; b++) begin
            y[8*b +: 8] = SUB_TABLE[x[8*b +: 8]];
        end
        return y;
    endfunction

    // Linear layer of the data rounds
    function automatic logic [31:0] data_mix(input logic [31:0] x);
        logic [31:0] s;
        s = substitute(x);
        return s ^ rol32(s, 2) ^ rol32(s, 10) ^ rol32(s, 18) ^ rol32(s, 24);
    endfunction

    // Linear layer of the key schedule
    function automatic logic [31:0] key_mix(input logic [31:0] x);
        logic [31:0] s;
        s = substitute(x);
        return s ^ rol32(s, 13) ^ rol32(s, 23);
    endfunction

    // Round constant: byte j of word i is 7 * (4i + j) mod 256
    function automatic logic [31:0] round_const(input int i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            w = {w[23:0], 8'((4 * i + j) * 7)};
        end
        return w;
    endfunction

    task automatic expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_hi_q[63:32] ^ SYS_PARAM_0;
        k[1] = key_hi_q[31:0]  ^ SYS_PARAM_1;
        k[2] = key_lo_q[63:32] ^ SYS_PARAM_2;
        k[3] = key_lo_q[31:0]  ^ SYS_PARAM_3;
        for (int i = 0; i < 32; i++) begin
            nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ round_const(i));
            round_key[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
        keys_valid = 1'b1;
    endtask

    // 32 rounds; decryption walks the round keys backwards
    function automatic logic [127:0] run_rounds(input logic [127:0] blk, input logic decrypt);
        logic [31:0] x [4];
        logic [31:0] rk, nx;
        x[0] = blk[127:96];
        x[1] = blk[95:64];
        x[2] = blk[63:32];
        x[3] = blk[31:0];
        for (int i = 0; i < 32; i++) begin
            rk = round_key[decrypt ? 31 - i : i];
            nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ rk);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        case (idx)
            CFG_KEY_HIGH: begin
                key_hi_q = val;
                keys_valid = 1'b0;
            end
            CFG_KEY_LOW: begin
                key_lo_q = val;
                keys_valid = 1'b0;
            end
            CFG_IV_HIGH:  iv_hi_q = val;
            CFG_IV_LOW:   iv_lo_q = val;
            CFG_CHAINING: cbc_on_q = val[0];
            default: ;  // unmapped index, no effect
        endcase
    endtask

    task automatic predict_block(input sm4_in_t req);
        logic [127:0] blk, res, chain;
        blk = {req.block_high, req.block_low};
        if (!keys_valid) expand_round_keys();
        if (cbc_on_q) begin
            if (req.first) begin
                chain_hi = iv_hi_q;
                chain_lo = iv_lo_q;
            end
            chain = {chain_hi, chain_lo};
            if (req.mode) begin
                res = run_rounds(blk, 1'b1) ^ chain;
                chain = blk;
            end else begin
                res = run_rounds(blk ^ chain, 1'b0);
                chain = res;
            end
            {chain_hi, chain_lo} = chain;
        end else begin
            // codebook: first bit plays no part, chain untouched
            res = run_rounds(blk, req.mode);
        end
        predicted_blocks.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input sm4_out_t got);
        sm4_out_t want;
        if (predicted_blocks.size() == 0) begin
            report_mismatch("result with no request pending", got.result_high, 'x);
        end else begin
            want = predicted_blocks.pop_front();
            if (got.result_high !== want.result_high)
                report_mismatch("result_high", got.result_high, want.result_high);
            if (got.result_low !== want.result_low)
                report_mismatch("result_low", got.result_low, want.result_low);
        end
    endtask

    // Monitor: register writes, accepted requests, accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_q = '0;
            key_lo_q = '0;
            iv_hi_q = '0;
            iv_lo_q = '0;
            cbc_on_q = 1'b0;
            keys_valid = 1'b0;
            chain_hi = '0;
            chain_lo = '0;
            predicted_blocks.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) apply_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready) predict_block(s_data);
            if (m_valid && m_ready) check_result(m_data);
        end
        blocks_in_flight <= predicted_blocks.size();
    end

endmodule

[tb/tb_sm4_block_cipher_cbc.sv]
// Top of the SM4 ECB/CBC cipher testbench: clock, reset, register writes and requests.
// Depends on sm4_pkg, sm4_block_cipher_cbc and sm4_cbc_checker.
`timescale 1ns / 100ps

module tb_sm4_block_cipher_cbc;
    import sm4_pkg::*;

    localparam logic        MODE_ENCRYPT  = 1'b0;
    localparam logic        MODE_DECRYPT  = 1'b1;
    localparam logic [63:0] CHAIN_ECB     = 64'd0;
    localparam logic [63:0] CHAIN_CBC     = 64'd1;
    localparam int          RESET_CYCLES  = 9;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_BLOCKS = 450;

    // Standard known-answer pair
    localparam logic [127:0] STD_KEY    = 128'h0123456789ABCDEFFEDCBA9876543210;
    localparam logic [127:0] STD_CIPHER = 128'h681EDF34D206965E86B3E94F536E4246;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    sm4_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    sm4_out_t             m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_wdata;

    int blocks_in_flight;
    int mismatches;
    int cycle_count = 0;
    int rx_stall_left = 0;
    bit quiet_burst = 1'b1;

    sm4_block_cipher_cbc uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sm4_cbc_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .blocks_in_flight (blocks_in_flight),
        .mismatches       (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // 64-bit value biased toward extremes
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return ~(64'd1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_burst || r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 3) != 0) return $urandom_range(1, 4);
        return $urandom_range(15, 90);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet_burst && $urandom_range(0, 7) == 0) begin
            rx_stall_left = pick_stall() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Only bit 0 matters; upper bits are junk
    task automatic set_chaining(input bit cbc);
        write_reg(CFG_CHAINING,
                  ({$urandom, $urandom} & ~64'd1) | (cbc ? CHAIN_CBC : CHAIN_ECB));
    endtask

    task automatic send_block(input logic op, input logic new_msg,
                              input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{mode: op, first: new_msg, block_high: hi, block_low: lo};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every predicted result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (blocks_in_flight != 0);
    endtask

    task automatic reconfigure();
        if ($urandom_range(0, 1)) write_reg(CFG_KEY_HIGH, pick_word());
        if ($urandom_range(0, 1)) write_reg(CFG_KEY_LOW, pick_word());
        if ($urandom_range(0, 2) == 0) write_reg(CFG_IV_HIGH, pick_word());
        if ($urandom_range(0, 2) == 0) write_reg(CFG_IV_LOW, pick_word());
        if ($urandom_range(0, 1)) set_chaining(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_IDX_W'(CFG_CHAINING + 1 + $urandom_range(0, 2)), pick_word());
    endtask

    // Messages: first request opens, rest chain on; some noise and mode mixing
    task automatic run_burst(input int count);
        int   left;
        int   msg_len;
        logic op;
        logic new_msg;
        quiet_burst = ($urandom_range(0, 3) == 0);
        left = count;
        while (left > 0) begin
            msg_len = $urandom_range(1, 8);
            if (msg_len > left) msg_len = left;
            op = $urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT;
            for (int n = 0; n < msg_len; n++) begin
                new_msg = (n == 0);
                if ($urandom_range(0, 9) == 0) new_msg = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0) op = ~op;
                send_block(op, new_msg, pick_word(), pick_word());
            end
            left -= msg_len;
        end
        drain();
    endtask

    initial begin
        int random_sent;
        int burst_len;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        quiet_burst = 1'b0;

        // Straight out of reset: zero key, codebook, keys built on first request
        send_block(MODE_ENCRYPT, 1'b0, '0, '0);
        send_block(MODE_DECRYPT, 1'b1, '1, '1);
        send_block(MODE_ENCRYPT, 1'b1, 64'h8000_0000_0000_0000, 64'h1);
        drain();

        // Chaining with no message start: chain runs from its reset value
        set_chaining(1'b1);
        send_block(MODE_ENCRYPT, 1'b0, pick_word(), pick_word());
        send_block(MODE_DECRYPT, 1'b0, pick_word(), pick_word());
        drain();

        // Known-answer pair in codebook mode
        write_reg(CFG_KEY_HIGH, STD_KEY[127:64]);
        write_reg(CFG_KEY_LOW, STD_KEY[63:0]);
        set_chaining(1'b0);
        send_block(MODE_ENCRYPT, 1'b0, STD_KEY[127:64], STD_KEY[63:0]);
        send_block(MODE_DECRYPT, 1'b0, STD_CIPHER[127:64], STD_CIPHER[63:0]);
        drain();

        // All-ones IV, mixed encrypt and decrypt in one message, key kept
        write_reg(CFG_IV_HIGH, '1);
        write_reg(CFG_IV_LOW, '1);
        set_chaining(1'b1);
        send_block(MODE_ENCRYPT, 1'b1, '0, '0);
        send_block(MODE_ENCRYPT, 1'b0, pick_word(), pick_word());
        send_block(MODE_DECRYPT, 1'b0, pick_word(), pick_word());
        send_block(MODE_DECRYPT, 1'b1, pick_word(), pick_word());
        drain();

        // New IV only takes hold at the next message start
        write_reg(CFG_IV_HIGH, '0);
        write_reg(CFG_IV_LOW, '0);
        send_block(MODE_ENCRYPT, 1'b0, pick_word(), pick_word());
        send_block(MODE_ENCRYPT, 1'b1, pick_word(), pick_word());
        drain();

        // Unmapped indexes, then a one-sided key change
        for (int i = CFG_CHAINING + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), '1);
        write_reg(CFG_KEY_HIGH, '1);
        send_block(MODE_DECRYPT, 1'b1, '1, '1);
        send_block(MODE_ENCRYPT, 1'b0, '1, '1);
        drain();

        // All-ones key, random IV
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_IV_HIGH, pick_word());
        write_reg(CFG_IV_LOW, pick_word());
        send_block(MODE_ENCRYPT, 1'b1, pick_word(), pick_word());
        send_block(MODE_DECRYPT, 1'b0, pick_word(), pick_word());
        drain();

        // Random phases
        random_sent = 0;
        while (random_sent < RANDOM_BLOCKS) begin
            reconfigure();
            burst_len = $urandom_range(4, 30);
            run_burst(burst_len);
            random_sent += burst_len;
        end

        quiet_burst = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
